// File: rtl/b64d_pkg.sv
// Shared types and constants for the Base64/Base64url stream decoder.
// No dependencies; imported by every module of the decoder.
package b64d_pkg;

  // Queue between classifier and decode engine
  localparam int unsigned QueueDepthDef = 2;

  // Symbol values with a special meaning in both alphabets
  localparam logic [5:0] SymPlusMinus = 6'd62;
  localparam logic [5:0] SymSlashUnder = 6'd63;
  localparam logic [3:0] LowNibbleMask = 4'hF;

  // One classified character as it travels through the queue
  typedef struct packed {
    logic [5:0] value;
    logic       ok;
    logic       last;
  } sym_t;

  // Position of the next character within its group of four
  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_THIRD  = 2'd2,
    POS_FOURTH = 2'd3
  } pos_e;

endpackage

// File: rtl/b64d_front.sv
// Front end: accepts characters and maps them to 6-bit symbol values.
// Depends on b64d_pkg.
module b64d_front (
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       char_code_i,
  input  logic             last_char_i,
  output logic             push_o,
  output b64d_pkg::sym_t   push_data_o,
  input  logic             q_ready_i
);
  import b64d_pkg::*;

  logic [5:0] value;
  logic       ok;

  // Both alphabets; everything else, '=' and the upper half included, is invalid
  always_comb begin
    value = '0;
    ok    = 1'b1;
    priority if (char_code_i >= 8'h41 && char_code_i <= 8'h5A) begin
      value = 6'(char_code_i - 8'h41);
    end else if (char_code_i >= 8'h61 && char_code_i <= 8'h7A) begin
      value = 6'(char_code_i - 8'h61 + 8'd26);
    end else if (char_code_i >= 8'h30 && char_code_i <= 8'h39) begin
      value = 6'(char_code_i - 8'h30 + 8'd52);
    end else if (char_code_i == 8'h2D || char_code_i == 8'h2B) begin
      value = SymPlusMinus;
    end else if (char_code_i == 8'h5F || char_code_i == 8'h2F) begin
      value = SymSlashUnder;
    end else begin
      ok = 1'b0;
    end
  end

  assign in_ready_o        = q_ready_i;
  assign push_o            = in_valid_i && q_ready_i;
  assign push_data_o.value = value;
  assign push_data_o.ok    = ok;
  assign push_data_o.last  = last_char_i;

endmodule

// File: rtl/b64d_queue.sv
// Short FIFO of classified symbols between front end and decode engine.
// Depends on b64d_pkg.
module b64d_queue #(
  parameter int unsigned Depth = b64d_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  b64d_pkg::sym_t push_data_i,
  output logic           ready_o,
  output logic           valid_o,
  output b64d_pkg::sym_t pop_data_o,
  input  logic           pop_i
);
  import b64d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  sym_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign ready_o    = (count_q != CntW'(Depth));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/b64d_back.sv
// Decode engine: group position, carried bits, stop handling, output register.
// Depends on b64d_pkg.
module b64d_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  b64d_pkg::sym_t q_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic           byte_valid_o,
  output logic [7:0]     data_byte_o,
  output logic           end_of_string_o,
  output logic           halted_o
);
  import b64d_pkg::*;

  pos_e       pos_q, pos_d;
  logic [5:0] carry_q, carry_d;
  logic       stop_q, stop_d;
  logic       third_inv_q, third_inv_d;

  logic       emit;
  logic [7:0] byte_val;

  logic       out_valid_q;
  logic       byte_valid_q;
  logic [7:0] data_byte_q;
  logic       eos_q;
  logic       halted_q;

  // Take the next symbol whenever the output register is free or draining
  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  // Next state
  always_comb begin
    pos_d       = pos_q;
    carry_d     = carry_q;
    stop_d      = stop_q;
    third_inv_d = third_inv_q;
    if (!stop_q) begin
      unique case (pos_q)
        POS_FIRST: begin
          if (q_data_i.ok) carry_d = q_data_i.value;
          else             stop_d  = 1'b1;
          third_inv_d = 1'b0;
        end
        POS_SECOND: begin
          if (q_data_i.ok) carry_d = {2'b00, q_data_i.value[3:0]};
          else             stop_d  = 1'b1;
        end
        POS_THIRD: begin
          if (q_data_i.ok) begin
            carry_d     = {4'b0000, q_data_i.value[1:0]};
            third_inv_d = 1'b0;
          end else begin
            third_inv_d = 1'b1;
          end
        end
        POS_FOURTH: begin
          carry_d     = '0;
          third_inv_d = 1'b0;
        end
        default: ;
      endcase
      if (!stop_d) pos_d = pos_e'(pos_q + 2'd1);
    end
  end

  // Byte assembly
  always_comb begin
    emit     = 1'b0;
    byte_val = '0;
    if (!stop_q && q_data_i.ok) begin
      unique case (pos_q)
        POS_FIRST: ;
        POS_SECOND: begin
          emit     = 1'b1;
          byte_val = {carry_q, q_data_i.value[5:4]};
        end
        POS_THIRD: begin
          emit     = 1'b1;
          byte_val = {carry_q[3:0] & LowNibbleMask, q_data_i.value[5:2]};
        end
        POS_FOURTH: begin
          emit     = !third_inv_q;
          byte_val = third_inv_q ? 8'h00 : {carry_q[1:0], q_data_i.value};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_FIRST;
      carry_q     <= '0;
      stop_q      <= 1'b0;
      third_inv_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        // Last marker returns the decode state to its reset values
        if (q_data_i.last) begin
          pos_q       <= POS_FIRST;
          carry_q     <= '0;
          stop_q      <= 1'b0;
          third_inv_q <= 1'b0;
        end else begin
          pos_q       <= pos_d;
          carry_q     <= carry_d;
          stop_q      <= stop_d;
          third_inv_q <= third_inv_d;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      byte_valid_q <= emit;
      data_byte_q  <= byte_val;
      eos_q        <= q_data_i.last;
      halted_q     <= stop_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign byte_valid_o    = byte_valid_q;
  assign data_byte_o     = data_byte_q;
  assign end_of_string_o = eos_q;
  assign halted_o        = halted_q;

endmodule

// File: rtl/base64url_stream_decoder.sv
// Channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------------
// input    | in_valid_i/ready_o   | char_code_i, last_char_i
// output   | out_valid_o/ready_i  | byte_valid_o, data_byte_o, end_of_string_o, halted_o
//
// One result per character, one character per cycle sustained while the output is not stalled.
// A character is classified into the queue, then decoded into the output register.
// Reset (rst_ni low) empties the queue and clears group position and carried bits.
// An output stall first fills the queue; in_ready_o drops only once it is full.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
module base64url_stream_decoder #(
  parameter int unsigned QueueDepth = b64d_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  input  logic       last_char_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       byte_valid_o,
  output logic [7:0] data_byte_o,
  output logic       end_of_string_o,
  output logic       halted_o
);
  import b64d_pkg::*;

  logic push;
  sym_t push_data;
  logic q_ready;
  logic q_valid;
  sym_t q_data;
  logic pop;

  b64d_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .last_char_i (last_char_i),
    .push_o      (push),
    .push_data_o (push_data),
    .q_ready_i   (q_ready)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .ready_o     (q_ready),
    .valid_o     (q_valid),
    .pop_data_o  (q_data),
    .pop_i       (pop)
  );

  b64d_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_data_i        (q_data),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .byte_valid_o    (byte_valid_o),
    .data_byte_o     (data_byte_o),
    .end_of_string_o (end_of_string_o),
    .halted_o        (halted_o)
  );

endmodule

// File: rtl/b64d_checker.sv
// Port-level checks for the stream decoder, bound to the top level.
// Depends on base64url_stream_decoder.
module b64d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       byte_valid_o,
  input logic [7:0] data_byte_o,
  input logic       end_of_string_o,
  input logic       halted_o
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(byte_valid_o) && $stable(data_byte_o)
      && $stable(end_of_string_o) && $stable(halted_o))
    else $error("result payload changed while stalled");

  // Input back-pressure only arises from an output stall
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending result");

  // A halted decoder yields no bytes, and an absent byte reads as zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (halted_o || !byte_valid_o) |-> !byte_valid_o && data_byte_o == 8'h00)
    else $error("byte produced while halted or non-zero filler");

endmodule

bind base64url_stream_decoder b64d_checker u_b64d_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .byte_valid_o    (byte_valid_o),
  .data_byte_o     (data_byte_o),
  .end_of_string_o (end_of_string_o),
  .halted_o        (halted_o)
);

// File: dv/base64url_stream_decoder_tb.sv
// Self-checking testbench for the Base64/Base64url stream decoder: directed table, then random
// strings with random idle and stall on both channels. Depends on b64d_pkg and the decoder RTL.
module base64url_stream_decoder_tb;
  import b64d_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 1700;
  localparam int unsigned MaxReports = 10;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       end_of_string;
    logic       halted;
  } result_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
    logic       typed;
    result_t    res;
  } row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] char_code_i;
  logic       last_char_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       byte_valid_o;
  logic [7:0] data_byte_o;
  logic       end_of_string_o;
  logic       halted_o;

  // decoder state as predicted
  pos_e       grp_pos;
  logic [5:0] carry;
  logic       stopped;
  logic       third_bad;

  result_t     pending_results[$];
  row_t        dir_rows[$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned chars_sent;
  int unsigned strings_sent;
  int unsigned bytes_seen;
  int unsigned halted_seen;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned stall_left;

  base64url_stream_decoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_code_i    (char_code_i),
    .last_char_i    (last_char_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .byte_valid_o   (byte_valid_o),
    .data_byte_o    (data_byte_o),
    .end_of_string_o(end_of_string_o),
    .halted_o       (halted_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic lookup_sym(input logic [7:0] ch, output logic [5:0] val);
    val = '0;
    if (ch >= "A" && ch <= "Z") val = 6'(ch - "A");
    else if (ch >= "a" && ch <= "z") val = 6'(ch - "a" + 26);
    else if (ch >= "0" && ch <= "9") val = 6'(ch - "0" + 52);
    else if (ch == "-" || ch == "+") val = SymPlusMinus;
    else if (ch == "_" || ch == "/") val = SymSlashUnder;
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic void clear_decoder();
    grp_pos   = POS_FIRST;
    carry     = '0;
    stopped   = 1'b0;
    third_bad = 1'b0;
  endfunction

  // Advance the predicted state by one character and return its result.
  function automatic result_t decode_char(input logic [7:0] ch, input logic last);
    result_t    r;
    logic [5:0] v;
    logic       ok;
    r  = '0;
    ok = lookup_sym(ch, v);
    if (!stopped) begin
      case (grp_pos)
        POS_FIRST: begin
          if (ok) carry = v;
          else stopped = 1'b1;
          third_bad = 1'b0;
        end
        POS_SECOND: begin
          if (ok) begin
            r.byte_valid = 1'b1;
            r.data_byte  = {carry, v[5:4]};
            carry        = v & {2'b00, LowNibbleMask};
          end else begin
            stopped = 1'b1;
          end
        end
        POS_THIRD: begin
          if (ok) begin
            r.byte_valid = 1'b1;
            r.data_byte  = {carry[3:0], v[5:2]};
            carry        = {4'b0000, v[1:0]};
            third_bad    = 1'b0;
          end else begin
            third_bad = 1'b1;
          end
        end
        default: begin
          if (ok && !third_bad) begin
            r.byte_valid = 1'b1;
            r.data_byte  = {carry[1:0], v};
          end
          carry     = '0;
          third_bad = 1'b0;
        end
      endcase
      if (!stopped) grp_pos = pos_e'(grp_pos + 2'd1);
    end
    r.end_of_string = last;
    r.halted        = stopped;
    if (last) clear_decoder();
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  function automatic logic [7:0] rand_sym();
    int unsigned v;
    v = $urandom_range(0, 63);
    if (v < 26) return 8'("A" + v);
    if (v < 52) return 8'("a" + v - 26);
    if (v < 62) return 8'("0" + v - 52);
    if (v == 62) return $urandom_range(0, 1) ? 8'("-") : 8'("+");
    return $urandom_range(0, 1) ? 8'("_") : 8'("/");
  endfunction

  function automatic row_t mk_row(input logic [7:0] ch, input logic last, input logic typed,
                                  input logic bv, input logic [7:0] db, input logic h);
    row_t r;
    r.char_code = ch;
    r.last_char = last;
    r.typed     = typed;
    r.res       = '{bv, db, last, h};
    return r;
  endfunction

  // Present one character, hold it until the transaction completes, then log its result.
  task automatic send_char(input logic [7:0] ch, input logic last, input result_t exp_res);
    @(negedge clk_i);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat (pick_gap()) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= ch;
    last_char_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.insert(pending_results.size(), exp_res);
    chars_sent++;
    if (last) strings_sent++;
  endtask

  task automatic push_char(input logic [7:0] ch, input logic last);
    result_t pred;
    pred = decode_char(ch, last);
    send_char(ch, last, pred);
  endtask

  // Output stall generator
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 99) < out_stall_pct) begin
      stall_left  <= pick_gap() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{byte_valid_o, data_byte_o, end_of_string_o, halted_o};
      if (got.byte_valid === 1'b1) bytes_seen++;
      if (got.halted === 1'b1) halted_seen++;
      if (pending_results.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReports)
          $display("ERROR: unexpected result bv=%b byte=%02h eos=%b halt=%b",
                   got.byte_valid, got.data_byte, got.end_of_string, got.halted);
      end else begin
        want = pending_results.pop_front();
        if (got.byte_valid !== want.byte_valid || got.data_byte !== want.data_byte ||
            got.end_of_string !== want.end_of_string || got.halted !== want.halted) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("ERROR: bv/byte/eos/halt exp %b/%02h/%b/%b got %b/%02h/%b/%b",
                     want.byte_valid, want.data_byte, want.end_of_string, want.halted,
                     got.byte_valid, got.data_byte, got.end_of_string, got.halted);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("base64url_stream_decoder_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned len;
    int unsigned npad;
    int unsigned mode;
    logic [7:0]  ch;
    result_t     pred;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    char_code_i   = '0;
    last_char_i   = 1'b0;
    out_ready_i   = 1'b0;
    err_cnt       = 0;
    cycle_cnt     = 0;
    chars_sent    = 0;
    strings_sent  = 0;
    bytes_seen    = 0;
    halted_seen   = 0;
    in_idle_pct   = 20;
    out_stall_pct = 20;
    stall_left    = 0;
    clear_decoder();

    // all ones, then both URL-safe and standard specials
    dir_rows.insert(dir_rows.size(), mk_row("/", 0, 1, 0, 8'h00, 0));
    dir_rows.insert(dir_rows.size(), mk_row("/", 0, 1, 1, 8'hFF, 0));
    dir_rows.insert(dir_rows.size(), mk_row("/", 0, 1, 1, 8'hFF, 0));
    dir_rows.insert(dir_rows.size(), mk_row("/", 0, 1, 1, 8'hFF, 0));
    dir_rows.insert(dir_rows.size(), mk_row("z", 0, 0, 0, 8'h00, 0));
    dir_rows.insert(dir_rows.size(), mk_row("+", 0, 0, 0, 8'h00, 0));
    dir_rows.insert(dir_rows.size(), mk_row("-", 0, 0, 0, 8'h00, 0));
    dir_rows.insert(dir_rows.size(), mk_row("_", 0, 0, 0, 8'h00, 0));
    // padding: one byte, nothing for the pads
    dir_rows.insert(dir_rows.size(), mk_row("Q", 0, 1, 0, 8'h00, 0));
    dir_rows.insert(dir_rows.size(), mk_row("Q", 0, 1, 1, 8'h41, 0));
    dir_rows.insert(dir_rows.size(), mk_row("=", 0, 1, 0, 8'h00, 0));
    dir_rows.insert(dir_rows.size(), mk_row("=", 1, 1, 0, 8'h00, 0));
    // lone trailing character
    dir_rows.insert(dir_rows.size(), mk_row("Z", 1, 1, 0, 8'h00, 0));
    // invalid first character halts until the last marker
    dir_rows.insert(dir_rows.size(), mk_row(8'h80, 0, 1, 0, 8'h00, 1));
    dir_rows.insert(dir_rows.size(), mk_row("A", 0, 1, 0, 8'h00, 1));
    dir_rows.insert(dir_rows.size(), mk_row(8'hFF, 1, 1, 0, 8'h00, 1));
    // invalid second character
    dir_rows.insert(dir_rows.size(), mk_row("A", 0, 1, 0, 8'h00, 0));
    dir_rows.insert(dir_rows.size(), mk_row(8'h00, 0, 1, 0, 8'h00, 1));
    dir_rows.insert(dir_rows.size(), mk_row("9", 1, 1, 0, 8'h00, 1));
    // invalid fourth character
    dir_rows.insert(dir_rows.size(), mk_row("A", 0, 0, 0, 8'h00, 0));
    dir_rows.insert(dir_rows.size(), mk_row("B", 0, 0, 0, 8'h00, 0));
    dir_rows.insert(dir_rows.size(), mk_row("9", 0, 0, 0, 8'h00, 0));
    dir_rows.insert(dir_rows.size(), mk_row(8'h7F, 1, 0, 0, 8'h00, 0));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      pred = decode_char(dir_rows[i].char_code, dir_rows[i].last_char);
      send_char(dir_rows[i].char_code, dir_rows[i].last_char,
                dir_rows[i].typed ? dir_rows[i].res : pred);
    end

    while (chars_sent < RandomItems + dir_rows.size()) begin
      // shift idle pressure now and then, including stretches with none
      if ($urandom_range(0, 7) == 0) begin
        in_idle_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
        out_stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 50);
      end
      len  = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24) : $urandom_range(25, 64);
      mode = $urandom_range(0, 9);
      npad = 0;
      if (mode <= 3) begin
        len  = ((len + 3) / 4) * 4;
        npad = $urandom_range(0, 2);
      end
      for (int unsigned i = 0; i < len; i++) begin
        if (mode <= 6) ch = (i >= len - npad) ? 8'("=") : rand_sym();
        else if (mode <= 8) ch = ($urandom_range(0, 99) < 12) ? 8'($urandom_range(0, 255))
                                                               : rand_sym();
        else ch = 8'($urandom_range(0, 255));
        push_char(ch, i == len - 1);
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("covered %0d strings, %0d characters, %0d bytes decoded, %0d halted results",
             strings_sent, chars_sent, bytes_seen, halted_seen);
    $display("mismatches: %0d", err_cnt);
    if (err_cnt == 0) begin
      $display("base64url_stream_decoder_tb: done, clean");
    end else begin
      $display("base64url_stream_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
